[design/graph_shortest_distances_macros.svh]
// ----------------------------------------------------------------------------
// graph shortest distances: assertion macros
// shared concurrent check forms, clocked on clk and disabled during rst
// ----------------------------------------------------------------------------
`ifndef GRAPH_SHORTEST_DISTANCES_MACROS_SVH
`define GRAPH_SHORTEST_DISTANCES_MACROS_SVH

// condition holds at every clock edge out of reset
`define GSD_ASSERT_HOLDS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define GSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// consequent holds in the same cycle as the antecedent
`define GSD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

[design/gsd_pkg.sv]
// ----------------------------------------------------------------------------
// gsd_pkg
// types, codes and fixed field widths shared by the shortest distance engine
// ----------------------------------------------------------------------------
package gsd_pkg;

  // fixed field widths
  localparam int STATE_W    = 10;
  localparam int COST_W     = 16;
  localparam int OP_W       = 3;
  localparam int OUT_DIST_W = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int NUM_W      = 11;

  // command codes
  typedef enum logic [OP_W-1:0] {
    OP_ADD_EDGE  = 3'd0,
    OP_MARK_GOAL = 3'd1,
    OP_RUN       = 3'd2,
    OP_READ      = 3'd3,
    OP_CLEAR     = 3'd4
  } op_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_FULL       = 2'd1,
    ST_RANGE      = 2'd2,
    ST_UNCOMPUTED = 2'd3
  } status_t;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STATE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_STATE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DO_FORWARD  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DO_BACKWARD = 2'd3;

  // controller states
  typedef enum logic [3:0] {
    S_RST_CLR,
    S_IDLE,
    S_EXEC,
    S_CLR,
    S_READ,
    S_INIT_RD,
    S_INIT_WR,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_SCAN_DONE,
    S_EDGE_RD,
    S_EDGE_CHK,
    S_DIST_CHK
  } state_t;

  // distance memory read address source
  typedef enum logic [1:0] {
    ADDR_IDX,
    ADDR_EDGE_TO,
    ADDR_INPUT
  } addr_sel_t;

  // distance memory write kind
  typedef enum logic [1:0] {
    WR_NONE,
    WR_SEED,
    WR_SETTLE,
    WR_RELAX
  } wr_kind_t;

  // one stored edge
  typedef struct packed {
    logic [STATE_W-1:0] src;
    logic [STATE_W-1:0] tgt;
    logic [COST_W-1:0]  cost;
  } edge_t;

  // controller to datapath commands
  typedef struct packed {
    logic      cap;
    logic      exec;
    logic      finish;
    logic      run_start;
    logic      mark_done;
    logic      set_dir;
    logic      dir_val;
    logic      idx_clr;
    logic      idx_inc;
    logic      eidx_clr;
    logic      eidx_inc;
    logic      goal_clr;
    logic      scan_chk;
    addr_sel_t addr_sel;
    wr_kind_t  wr_kind;
  } ctl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            n_zero;
    logic            do_fwd;
    logic            do_bwd;
    logic            dir;
    logic            idx_end;
    logic            idx_gend;
    logic            eidx_end;
    logic            edge_none;
    logic            found;
    logic            edge_match;
  } dp_sts_t;

endpackage

[design/gsd_ctrl.sv]
// ----------------------------------------------------------------------------
// gsd_ctrl
// sequencer for command decode, goal clearing, seeding, minimum scan and
// edge relaxation of the label-setting search
// ----------------------------------------------------------------------------
module gsd_ctrl import gsd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  dp_sts_t  sts,
  output ctl_cmd_t cmd,
  output logic     busy
);

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RST_CLR;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  // next state and commands
  always_comb begin
    cmd        = '0;
    cmd.addr_sel = ADDR_IDX;
    cmd.wr_kind  = WR_NONE;
    state_next = state;
    case (state)
      S_RST_CLR: begin
        cmd.goal_clr = 1'b1;
        if (sts.idx_gend) begin
          cmd.idx_clr = 1'b1;
          state_next  = S_IDLE;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.cap     = 1'b1;
          cmd.idx_clr = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        case (sts.op)
          OP_ADD_EDGE, OP_MARK_GOAL: begin
            cmd.exec   = 1'b1;
            cmd.finish = 1'b1;
            state_next = S_IDLE;
          end
          OP_CLEAR: begin
            cmd.exec   = 1'b1;
            state_next = S_CLR;
          end
          OP_READ: begin
            cmd.addr_sel = ADDR_INPUT;
            state_next   = S_READ;
          end
          OP_RUN: begin
            cmd.run_start = 1'b1;
            if (sts.n_zero) begin
              cmd.finish = 1'b1;
              state_next = S_IDLE;
            end else if (sts.do_fwd) begin
              cmd.set_dir = 1'b1;
              cmd.dir_val = 1'b0;
              state_next  = S_INIT_RD;
            end else if (sts.do_bwd) begin
              cmd.set_dir = 1'b1;
              cmd.dir_val = 1'b1;
              state_next  = S_INIT_RD;
            end else begin
              cmd.finish = 1'b1;
              state_next = S_IDLE;
            end
          end
          default: begin
            cmd.finish = 1'b1;
            state_next = S_IDLE;
          end
        endcase
      end
      S_CLR: begin
        cmd.goal_clr = 1'b1;
        if (sts.idx_gend) begin
          cmd.idx_clr = 1'b1;
          cmd.finish  = 1'b1;
          state_next  = S_IDLE;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_READ: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      // seed every active state, goal mark read in S_INIT_RD ahead of the write in S_INIT_WR
      S_INIT_RD: begin
        state_next = S_INIT_WR;
      end
      S_INIT_WR: begin
        cmd.wr_kind = WR_SEED;
        if (sts.idx_end) begin
          cmd.idx_clr = 1'b1;
          state_next  = S_SCAN_RD;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_INIT_RD;
        end
      end
      // linear scan for the frontier state of least distance
      S_SCAN_RD: begin
        cmd.addr_sel = ADDR_IDX;
        state_next   = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        cmd.scan_chk = 1'b1;
        if (sts.idx_end) begin
          state_next = S_SCAN_DONE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_SCAN_RD;
        end
      end
      S_SCAN_DONE: begin
        if (!sts.found) begin
          cmd.mark_done = 1'b1;
          if (!sts.dir && sts.do_bwd) begin
            cmd.set_dir = 1'b1;
            cmd.dir_val = 1'b1;
            cmd.idx_clr = 1'b1;
            state_next  = S_INIT_RD;
          end else begin
            cmd.finish = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          cmd.wr_kind  = WR_SETTLE;
          cmd.eidx_clr = 1'b1;
          if (sts.edge_none) begin
            cmd.idx_clr = 1'b1;
            state_next  = S_SCAN_RD;
          end else begin
            state_next = S_EDGE_RD;
          end
        end
      end
      // walk the edge store for edges leaving the settled state
      S_EDGE_RD: begin
        state_next = S_EDGE_CHK;
      end
      S_EDGE_CHK: begin
        if (sts.edge_match) begin
          cmd.addr_sel = ADDR_EDGE_TO;
          state_next   = S_DIST_CHK;
        end else if (sts.eidx_end) begin
          cmd.idx_clr = 1'b1;
          state_next  = S_SCAN_RD;
        end else begin
          cmd.eidx_inc = 1'b1;
          state_next   = S_EDGE_RD;
        end
      end
      S_DIST_CHK: begin
        cmd.wr_kind = WR_RELAX;
        if (sts.eidx_end) begin
          cmd.idx_clr = 1'b1;
          state_next  = S_SCAN_RD;
        end else begin
          cmd.eidx_inc = 1'b1;
          state_next   = S_EDGE_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[design/gsd_datapath.sv]
// ----------------------------------------------------------------------------
// gsd_datapath
// configuration, edge store, goal marks, distance memories and the compare
// and add logic of the search
// ----------------------------------------------------------------------------
`include "graph_shortest_distances_macros.svh"

module gsd_datapath import gsd_pkg::*; #(
  parameter int MAX_STATES = 1024,
  parameter int MAX_EDGES  = 4096,
  parameter int DIST_BITS  = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ctl_cmd_t              cmd,
  output dp_sts_t               sts,
  input  logic [OP_W-1:0]       opcode,
  input  logic [STATE_W-1:0]    state_index,
  input  logic [STATE_W-1:0]    target_state,
  input  logic [COST_W-1:0]     edge_cost,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic [OUT_DIST_W-1:0] forward_distance,
  output logic [OUT_DIST_W-1:0] backward_distance,
  output logic                  forward_reached,
  output logic                  backward_reached,
  output logic [1:0]            status,
  output logic                  done
);

  localparam int SW    = $clog2(MAX_STATES);
  localparam int NW    = $clog2(MAX_STATES + 1);
  localparam int EAW   = $clog2(MAX_EDGES);
  localparam int ECW   = $clog2(MAX_EDGES + 1);
  localparam int MW    = DIST_BITS + 2;
  localparam int SUM_W = ((DIST_BITS > COST_W) ? DIST_BITS : COST_W) + 1;
  localparam int EXT_W = (DIST_BITS > OUT_DIST_W) ? DIST_BITS : OUT_DIST_W;
  localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

  // configuration registers
  logic [NUM_W-1:0]   state_count;
  logic [STATE_W-1:0] init_state;
  logic               do_fwd;
  logic               do_bwd;

  // captured transaction
  logic [OP_W-1:0]    op_q;
  logic [STATE_W-1:0] si_q;
  logic [STATE_W-1:0] ti_q;
  logic [COST_W-1:0]  cost_q;

  // engine state
  logic [ECW-1:0]       edge_count;
  logic [1:0]           computed;
  status_t              run_status;
  logic [NW-1:0]        run_n;
  logic [SW-1:0]        idx;
  logic [EAW-1:0]       eidx;
  logic                 found;
  logic [SW-1:0]        best;
  logic [DIST_BITS-1:0] best_dist;
  logic                 dir;

  // memories, entry is {frontier, reached, distance}
  edge_t          edge_mem [MAX_EDGES];
  logic           goal_mem [MAX_STATES];
  logic [MW-1:0]  fwd_mem  [MAX_STATES];
  logic [MW-1:0]  bwd_mem  [MAX_STATES];
  edge_t          edge_q;
  logic           goal_q;
  logic [MW-1:0]  rd_f;
  logic [MW-1:0]  rd_b;

  logic [NW-1:0]        n_act;
  logic                 edge_full;
  logic                 edge_range;
  logic                 goal_range;
  logic                 edge_we;
  logic                 goal_set;
  logic                 clr;
  logic [STATE_W-1:0]   edge_from;
  logic [STATE_W-1:0]   edge_to;
  logic [SW-1:0]        edge_to_a;
  logic                 edge_match;
  logic [MW-1:0]        cur;
  logic                 better;
  logic [SUM_W-1:0]     sum;
  logic [DIST_BITS-1:0] nd;
  logic                 improve;
  logic                 mem_we;
  logic [SW-1:0]        mem_waddr;
  logic [MW-1:0]        mem_wdata;
  logic                 seed;
  logic [SW-1:0]        rd_addr;
  logic [EXT_W-1:0]     ext_f;
  logic [EXT_W-1:0]     ext_b;
  logic [OUT_DIST_W-1:0] sat_f;
  logic [OUT_DIST_W-1:0] sat_b;
  status_t              res_status;
  logic                 res_seen;
  logic                 res_fr;
  logic                 res_br;

  // active state count, clamped to the store depth
  always_comb begin
    if (32'(state_count) > 32'(MAX_STATES)) begin
      n_act = NW'(MAX_STATES);
    end else begin
      n_act = NW'(state_count);
    end
  end

  // simple command qualifiers
  assign edge_full  = 32'(edge_count) >= 32'(MAX_EDGES);
  assign edge_range = (32'(si_q) >= 32'(MAX_STATES)) || (32'(ti_q) >= 32'(MAX_STATES));
  assign goal_range = 32'(si_q) >= 32'(MAX_STATES);
  assign edge_we    = cmd.exec && (op_q == OP_ADD_EDGE) && !edge_full && !edge_range;
  assign goal_set   = cmd.exec && (op_q == OP_MARK_GOAL) && !goal_range;
  assign clr        = cmd.exec && (op_q == OP_CLEAR);

  // edge endpoints in the current search direction
  assign edge_from  = dir ? edge_q.tgt : edge_q.src;
  assign edge_to    = dir ? edge_q.src : edge_q.tgt;
  assign edge_to_a  = SW'(edge_to);
  assign edge_match = (32'(edge_from) == 32'(best)) && (32'(edge_to) < 32'(n_act));

  // scan compare and relaxation add with saturation
  assign cur     = dir ? rd_b : rd_f;
  assign better  = cur[MW-1] && (!found || (cur[DIST_BITS-1:0] < best_dist));
  assign sum     = SUM_W'(best_dist) + SUM_W'(edge_q.cost);
  assign nd      = (sum > SUM_W'(DIST_MAX)) ? DIST_MAX : DIST_BITS'(sum);
  assign improve = !cur[MW-2] || (nd < cur[DIST_BITS-1:0]);
  assign seed    = dir ? goal_q : (32'(idx) == 32'(init_state));

  // distance memory write port
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx;
    mem_wdata = '0;
    case (cmd.wr_kind)
      WR_SEED: begin
        mem_we    = 1'b1;
        mem_wdata = {seed, seed, {DIST_BITS{1'b0}}};
      end
      WR_SETTLE: begin
        mem_we    = 1'b1;
        mem_waddr = best;
        mem_wdata = {1'b0, 1'b1, best_dist};
      end
      WR_RELAX: begin
        mem_we    = improve;
        mem_waddr = edge_to_a;
        mem_wdata = {1'b1, 1'b1, nd};
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // distance memory read address
  always_comb begin
    case (cmd.addr_sel)
      ADDR_EDGE_TO: rd_addr = edge_to_a;
      ADDR_INPUT:   rd_addr = SW'(si_q);
      default:      rd_addr = idx;
    endcase
  end

  // edge store
  always_ff @(posedge clk) begin
    if (edge_we) begin
      edge_mem[edge_count[EAW-1:0]] <= '{src: si_q, tgt: ti_q, cost: cost_q};
    end
    edge_q <= edge_mem[eidx];
  end

  // goal marks
  always_ff @(posedge clk) begin
    if (cmd.goal_clr) begin
      goal_mem[idx] <= 1'b0;
    end else if (goal_set) begin
      goal_mem[SW'(si_q)] <= 1'b1;
    end
    goal_q <= goal_mem[idx];
  end

  // forward and backward distance memories
  always_ff @(posedge clk) begin
    if (mem_we && !dir) begin
      fwd_mem[mem_waddr] <= mem_wdata;
    end
    rd_f <= fwd_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (mem_we && dir) begin
      bwd_mem[mem_waddr] <= mem_wdata;
    end
    rd_b <= bwd_mem[rd_addr];
  end

  // output saturation to the result width
  assign ext_f = EXT_W'(rd_f[DIST_BITS-1:0]);
  assign ext_b = EXT_W'(rd_b[DIST_BITS-1:0]);
  assign sat_f = (ext_f > EXT_W'({OUT_DIST_W{1'b1}})) ? '1 : ext_f[OUT_DIST_W-1:0];
  assign sat_b = (ext_b > EXT_W'({OUT_DIST_W{1'b1}})) ? '1 : ext_b[OUT_DIST_W-1:0];

  // states at or above the count of the last run were left unreached by it
  assign res_seen = 32'(si_q) < 32'(run_n);

  // result of the finishing transaction
  always_comb begin
    res_status = ST_OK;
    res_fr     = 1'b0;
    res_br     = 1'b0;
    case (op_q)
      OP_ADD_EDGE: begin
        if (edge_full) begin
          res_status = ST_FULL;
        end else if (edge_range) begin
          res_status = ST_RANGE;
        end
      end
      OP_MARK_GOAL: begin
        if (goal_range) begin
          res_status = ST_RANGE;
        end
      end
      OP_RUN: begin
        // a run that ends at once has searched nothing and is always ok
        res_status = cmd.run_start ? ST_OK : run_status;
      end
      OP_READ: begin
        if (32'(si_q) >= 32'(n_act)) begin
          res_status = ST_RANGE;
        end else if (computed == 2'b00) begin
          res_status = ST_UNCOMPUTED;
        end else begin
          res_fr = computed[0] && res_seen && rd_f[MW-2];
          res_br = computed[1] && res_seen && rd_b[MW-2];
        end
      end
      default: begin
        res_status = ST_OK;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state_count <= '0;
      init_state  <= '0;
      do_fwd      <= 1'b1;
      do_bwd      <= 1'b1;
      edge_count  <= '0;
      computed    <= 2'b00;
      idx         <= '0;
      eidx        <= '0;
      found       <= 1'b0;
      done        <= 1'b0;
    end else begin
      done <= cmd.finish;
      // configuration writes
      if (cfg_write) begin
        case (cfg_index)
          CFG_STATE_COUNT: state_count <= cfg_data;
          CFG_INIT_STATE:  init_state  <= cfg_data[STATE_W-1:0];
          CFG_DO_FORWARD:  do_fwd      <= cfg_data[0];
          CFG_DO_BACKWARD: do_bwd      <= cfg_data[0];
          default:         do_bwd      <= do_bwd;
        endcase
      end
      // edge count
      if (clr) begin
        edge_count <= '0;
      end else if (edge_we) begin
        edge_count <= edge_count + 1'b1;
      end
      // computed directions
      if (clr || edge_we || goal_set) begin
        computed <= 2'b00;
      end else if (cmd.run_start) begin
        computed <= (n_act == '0) ? 2'b11 : 2'b00;
      end else if (cmd.mark_done) begin
        computed[dir] <= 1'b1;
      end
      // state and edge counters
      if (cmd.idx_clr) begin
        idx   <= '0;
        found <= 1'b0;
      end else begin
        if (cmd.idx_inc) begin
          idx <= idx + 1'b1;
        end
        if (cmd.scan_chk && better) begin
          found <= 1'b1;
        end
      end
      if (cmd.eidx_clr) begin
        eidx <= '0;
      end else if (cmd.eidx_inc) begin
        eidx <= eidx + 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      op_q   <= opcode;
      si_q   <= state_index;
      ti_q   <= target_state;
      cost_q <= edge_cost;
    end
    if (cmd.run_start) begin
      run_n <= n_act;
      if (do_fwd && (n_act != '0) && !(32'(init_state) < 32'(n_act))) begin
        run_status <= ST_RANGE;
      end else begin
        run_status <= ST_OK;
      end
    end
    if (cmd.set_dir) begin
      dir <= cmd.dir_val;
    end
    if (cmd.scan_chk && better) begin
      best      <= idx;
      best_dist <= cur[DIST_BITS-1:0];
    end
    if (cmd.finish) begin
      status            <= res_status;
      forward_reached   <= res_fr;
      backward_reached  <= res_br;
      forward_distance  <= res_fr ? sat_f : '0;
      backward_distance <= res_br ? sat_b : '0;
    end
  end

  // status to the controller
  always_comb begin
    sts            = '0;
    sts.op         = op_q;
    sts.n_zero     = (n_act == '0);
    sts.do_fwd     = do_fwd;
    sts.do_bwd     = do_bwd;
    sts.dir        = dir;
    sts.idx_end    = (32'(idx) + 32'd1) == 32'(n_act);
    sts.idx_gend   = 32'(idx) == (32'(MAX_STATES) - 32'd1);
    sts.eidx_end   = (32'(eidx) + 32'd1) >= 32'(edge_count);
    sts.edge_none  = (edge_count == '0);
    sts.found      = found;
    sts.edge_match = edge_match;
  end

  // checks
  `GSD_ASSERT_HOLDS(a_edge_bound, 32'(edge_count) <= 32'(MAX_EDGES), "edge count beyond store")
  `GSD_ASSERT_SAME(a_settle_found, cmd.wr_kind == WR_SETTLE, found, "settle without a frontier state")
  `GSD_ASSERT_NEXT(a_edge_clears, edge_we, computed == 2'b00, "edge load left distances marked computed")

endmodule

[design/graph_shortest_distances.sv]
// ----------------------------------------------------------------------------
// graph_shortest_distances
// shortest distance engine: loads weighted directed edges and goal marks,
// then computes forward distances from the initial state and backward
// distances to the nearest goal, read back one state at a time
// ----------------------------------------------------------------------------
// usage
//   a command transaction is taken when start is high and busy is low; its
//   single result appears for one cycle with done high and cannot be held off
//   configuration is written through cfg_write/cfg_index/cfg_data while idle
// sequence
//   add edge, mark goal and unused codes: finished in the execute state
//   read state: the stored entries are fetched, then the result is registered
//   clear: drops all edges, then a sweep clears every goal mark
//   run: per direction a seeding pass over the n active states, then a minimum
//   scan over them for each settled state and one final scan, plus a walk of
//   every stored edge after each settled state (with a distance check when it
//   leaves that state towards an active state), n being the active state count
// reset
//   after rst the block stays busy while it clears all goal marks
// ----------------------------------------------------------------------------
module graph_shortest_distances import gsd_pkg::*; #(
  parameter int MAX_STATES = 1024,
  parameter int MAX_EDGES  = 4096,
  parameter int DIST_BITS  = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [OP_W-1:0]       opcode,
  input  logic [STATE_W-1:0]    state_index,
  input  logic [STATE_W-1:0]    target_state,
  input  logic [COST_W-1:0]     edge_cost,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  done,
  output logic [OUT_DIST_W-1:0] forward_distance,
  output logic [OUT_DIST_W-1:0] backward_distance,
  output logic                  forward_reached,
  output logic                  backward_reached,
  output logic [1:0]            status
);

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  // sequencer
  gsd_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // storage and arithmetic
  gsd_datapath #(
    .MAX_STATES (MAX_STATES),
    .MAX_EDGES  (MAX_EDGES),
    .DIST_BITS  (DIST_BITS)
  ) u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .sts               (sts),
    .opcode            (opcode),
    .state_index       (state_index),
    .target_state      (target_state),
    .edge_cost         (edge_cost),
    .cfg_write         (cfg_write),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .forward_distance  (forward_distance),
    .backward_distance (backward_distance),
    .forward_reached   (forward_reached),
    .backward_reached  (backward_reached),
    .status            (status),
    .done              (done)
  );

endmodule
